// ===== hdl/vcss_pkg.sv =====
`default_nettype none
package vcss_pkg;

    localparam int CHANNELS    = 4;
    localparam int VALUE_WIDTH = 16;
    localparam int SQRT_STEPS  = 17;   // 34-bit radicand, one result bit per step
    localparam int DIV_STEPS   = 16;   // quotient always fits in 16 bits
    localparam int CNT_W       = 5;

    localparam logic [16:0] ALPHA_ONE  = 17'h10000;
    localparam logic [33:0] SQRT_TOP   = 34'h1_0000_0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ALPHA      = 3'd0,
        CFG_XY_LIMIT   = 3'd1,
        CFG_Z_LIMIT    = 3'd2,
        CFG_YAW_LIMIT  = 3'd3,
        CFG_BOUNDS_EN  = 3'd4,
        CFG_MIN_BOUNDS = 3'd5,
        CFG_MAX_BOUNDS = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [16:0] alpha;
        logic [14:0] xy_step_max;
        logic [14:0] z_limit;
        logic [14:0] yaw_limit;
        logic        bounds_en;
        logic [63:0] min_bounds;
        logic [63:0] max_bounds;
    } vcss_cfg_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SMOOTH,
        MUL_SQ0,
        MUL_SQ1,
        MUL_LIM
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_SQUARE,
        ST_SQRT,
        ST_LIMIT,
        ST_DIV,
        ST_DIV_STORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load;
        mul_op_t    mul_op;
        logic [1:0] ch;
        logic       axis;
        logic       sqrt_step;
        logic       div_step;
        logic       div_store;
        logic       commit;
    } vcss_cmd_t;

    typedef struct packed {
        logic scale_needed;
        logic out_free;
    } vcss_status_t;

    function automatic logic signed [15:0] bound_clamp(
        input logic signed [15:0] v,
        input logic               en,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [15:0] t;
        t = v;
        if (en) begin
            if (t > hi) t = hi;
            if (t < lo) t = lo;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/vcss_ctrl.sv =====
`default_nettype none
module vcss_ctrl
    import vcss_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic         s_op,
    output logic              s_ready,
    input  wire vcss_status_t st,
    output vcss_cmd_t         cmd
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        cmd.ch     = cnt_reg[1:0];
        cmd.axis   = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (!s_op) state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                cmd.mul_op = MUL_SMOOTH;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CHANNELS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.mul_op = cnt_reg[0] ? MUL_SQ1 : MUL_SQ0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg[0]) begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    cnt_next   = '0;
                    axis_next  = 1'b0;
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                if (st.scale_needed) begin
                    cmd.mul_op = MUL_LIM;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE: begin
                cmd.div_store = 1'b1;
                if (axis_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    axis_next  = 1'b1;
                    state_next = ST_LIMIT;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/vcss_dp.sv =====
`default_nettype none
module vcss_dp
    import vcss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire vcss_cfg_t          cfg,
    input  wire vcss_cmd_t          cmd,
    output vcss_status_t            st,
    input  wire logic               s_op,
    input  wire logic signed [15:0] s_measured_vx,
    input  wire logic signed [15:0] s_measured_vy,
    input  wire logic signed [15:0] s_measured_vz,
    input  wire logic signed [15:0] s_cmd_vx,
    input  wire logic signed [15:0] s_cmd_vy,
    input  wire logic signed [15:0] s_cmd_vz,
    input  wire logic signed [15:0] s_cmd_yaw_rate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_vx,
    output logic signed [15:0]      m_out_vy,
    output logic signed [15:0]      m_out_vz,
    output logic signed [15:0]      m_out_yaw_rate
);

    logic signed [15:0] held_reg  [CHANNELS];
    logic               held_valid_reg;
    logic signed [15:0] cmdv_reg  [CHANNELS];
    logic signed [16:0] delta_reg [CHANNELS];
    logic [33:0]        x_reg, r_reg, bit_reg;
    logic [17:0]        rem_reg;
    logic [15:0]        dlow_reg;
    logic signed [15:0] out_reg   [CHANNELS];
    logic               out_valid_reg;

    logic signed [15:0] lo_b [CHANNELS];
    logic signed [15:0] hi_b [CHANNELS];
    logic signed [15:0] meas [CHANNELS];
    logic signed [15:0] incmd [CHANNELS];
    logic signed [15:0] fin  [CHANNELS];

    logic [1:0]         axis_idx;
    logic [16:0]        a_eff;
    logic signed [16:0] diff;
    logic               diff_neg;
    logic [16:0]        diff_mag;
    logic signed [16:0] dsel;
    logic [16:0]        dsel_mag;
    logic [16:0]        mul_a, mul_b;
    logic [33:0]        mul_p;
    logic [15:0]        smooth_q;
    logic [33:0]        rb;
    logic [16:0]        root;
    logic [17:0]        div_t;
    logic               div_ge;
    logic signed [16:0] q_signed;

    assign meas[0]  = s_measured_vx;
    assign meas[1]  = s_measured_vy;
    assign meas[2]  = s_measured_vz;
    assign meas[3]  = '0;
    assign incmd[0] = s_cmd_vx;
    assign incmd[1] = s_cmd_vy;
    assign incmd[2] = s_cmd_vz;
    assign incmd[3] = s_cmd_yaw_rate;

    assign axis_idx = {1'b0, cmd.axis};

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            lo_b[i] = cfg.min_bounds[16*i +: 16];
            hi_b[i] = cfg.max_bounds[16*i +: 16];
        end
    end

    assign a_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

    // shared 17x17 multiplier
    always_comb begin
        diff     = 17'(cmdv_reg[cmd.ch]) - 17'(held_reg[cmd.ch]);
        diff_neg = diff[16];
        diff_mag = diff_neg ? 17'(-diff) : 17'(diff);
        unique case (cmd.mul_op)
            MUL_SQ1:  dsel = delta_reg[1];
            MUL_LIM:  dsel = delta_reg[axis_idx];
            default:  dsel = delta_reg[0];
        endcase
        dsel_mag = dsel[16] ? 17'(-dsel) : 17'(dsel);
        unique case (cmd.mul_op)
            MUL_SMOOTH: begin
                mul_a = diff_mag;
                mul_b = a_eff;
            end
            MUL_SQ0, MUL_SQ1: begin
                mul_a = dsel_mag;
                mul_b = dsel_mag;
            end
            MUL_LIM: begin
                mul_a = dsel_mag;
                mul_b = {2'b00, cfg.xy_step_max};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p    = mul_a * mul_b;
        smooth_q = mul_p[31:16];
    end

    assign rb     = r_reg + bit_reg;
    assign root   = r_reg[16:0];
    assign div_t  = {rem_reg[16:0], dlow_reg[15]};
    assign div_ge = div_t >= {1'b0, root};
    assign q_signed = delta_reg[axis_idx][16] ? -$signed({1'b0, dlow_reg})
                                              :  $signed({1'b0, dlow_reg});

    // z and yaw step limits, final sum, saturate, bound clamp
    always_comb begin
        logic signed [16:0] d;
        logic signed [17:0] lim;
        logic signed [17:0] sum;
        logic signed [15:0] sat;
        for (int i = 0; i < CHANNELS; i++) begin
            d   = delta_reg[i];
            lim = '0;
            if (i == 2) lim = $signed({3'b000, cfg.z_limit});
            if (i == 3) lim = $signed({3'b000, cfg.yaw_limit});
            if (i >= 2) begin
                if (18'(d) > lim)  d = 17'(lim);
                if (18'(d) < -lim) d = 17'(-lim);
            end
            sum = 18'(held_reg[i]) + 18'(d);
            if (sum > 18'sd32767)       sat = 16'sh7fff;
            else if (sum < -18'sd32768) sat = -16'sh8000;
            else                        sat = sum[15:0];
            fin[i] = bound_clamp(sat, cfg.bounds_en, lo_b[i], hi_b[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) held_reg[i] <= '0;
        end else begin
            if (cmd.commit) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (cmd.load) begin
                if (s_op) begin
                    held_valid_reg <= 1'b0;
                    for (int i = 0; i < CHANNELS; i++) held_reg[i] <= '0;
                end else if (!held_valid_reg) begin
                    held_valid_reg <= 1'b1;
                    for (int i = 0; i < CHANNELS; i++)
                        held_reg[i] <= bound_clamp(meas[i], cfg.bounds_en, lo_b[i], hi_b[i]);
                end
            end
            if (cmd.commit) begin
                for (int i = 0; i < CHANNELS; i++) held_reg[i] <= fin[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < CHANNELS; i++) cmdv_reg[i] <= incmd[i];
        end
        unique case (cmd.mul_op)
            MUL_SMOOTH: delta_reg[cmd.ch] <= diff_neg ? -$signed({1'b0, smooth_q})
                                                      :  $signed({1'b0, smooth_q});
            MUL_SQ0:    x_reg <= mul_p;
            MUL_SQ1: begin
                x_reg   <= x_reg + mul_p;
                r_reg   <= '0;
                bit_reg <= SQRT_TOP;
            end
            MUL_LIM: begin
                rem_reg  <= {3'b000, mul_p[30:16]};
                dlow_reg <= mul_p[15:0];
            end
            default: ;
        endcase
        if (cmd.sqrt_step) begin
            if (x_reg >= rb) begin
                x_reg <= x_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_step) begin
            rem_reg  <= div_ge ? div_t - {1'b0, root} : div_t;
            dlow_reg <= {dlow_reg[14:0], div_ge};
        end
        if (cmd.div_store) delta_reg[axis_idx] <= q_signed;
        if (cmd.commit) begin
            for (int i = 0; i < CHANNELS; i++) out_reg[i] <= fin[i];
        end
    end

    assign st = vcss_status_t'{scale_needed: (root > {2'b00, cfg.xy_step_max}),
                               out_free:     (!out_valid_reg || m_ready)};

    assign m_valid        = out_valid_reg;
    assign m_out_vx       = out_reg[0];
    assign m_out_vy       = out_reg[1];
    assign m_out_vz       = out_reg[2];
    assign m_out_yaw_rate = out_reg[3];

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> st.out_free)
        else $error("result committed over an untaken word");
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (m_valid && held_valid_reg))
        else $error("commit did not raise output valid and held valid");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && s_op) |=> !held_valid_reg)
        else $error("clear word left held command valid");

endmodule
`default_nettype wire

// ===== hdl/velocity_command_slew_smoother.sv =====
// Velocity command slew smoother: x, y, z velocity and yaw rate, signed Q8.8.
// Input channel (s_valid/s_ready): one word per control update; s_op=0 applies
// the command, s_op=1 clears the held command and yields no result.
// Output channel (m_valid/m_ready): one word per apply, the new held command.
// Config: cfg_wr_en/cfg_index/cfg_wdata, written by the user only while the
// block is idle; the block itself does not enforce it. One word is in flight
// at a time. An apply runs smoothing, squares and a 17-step square root, then,
// when the xy step must be scaled, two 16-step restoring divides before it
// commits; the smoothing, the squares and the divide dividends share one
// 17x17 multiplier. A clear word is handled in idle and starts no sequence.
// The result sits in an output register, so s_ready returns while the word
// waits for m_ready; a stalled receiver only holds the next apply at its
// final step until the output register frees.
// Reset (aresetn low, synchronous): config to defaults (alpha one, step
// limits 256, bounds off), held command cleared and unseeded, output empty.
// The first apply after reset or clear seeds from the measured velocity.
`default_nettype none
module velocity_command_slew_smoother
    import vcss_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic signed [15:0] s_measured_vx,
    input  wire logic signed [15:0] s_measured_vy,
    input  wire logic signed [15:0] s_measured_vz,
    input  wire logic signed [15:0] s_cmd_vx,
    input  wire logic signed [15:0] s_cmd_vy,
    input  wire logic signed [15:0] s_cmd_vz,
    input  wire logic signed [15:0] s_cmd_yaw_rate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_vx,
    output logic signed [15:0]      m_out_vy,
    output logic signed [15:0]      m_out_vz,
    output logic signed [15:0]      m_out_yaw_rate,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_wdata
);

    vcss_cfg_t    cfg_reg;
    vcss_cmd_t    cmd;
    vcss_status_t st;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha       <= ALPHA_ONE;
            cfg_reg.xy_step_max <= 15'd256;
            cfg_reg.z_limit     <= 15'd256;
            cfg_reg.yaw_limit   <= 15'd256;
            cfg_reg.bounds_en   <= 1'b0;
            cfg_reg.min_bounds  <= '0;
            cfg_reg.max_bounds  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ALPHA:      cfg_reg.alpha       <= cfg_wdata[16:0];
                CFG_XY_LIMIT:   cfg_reg.xy_step_max <= cfg_wdata[14:0];
                CFG_Z_LIMIT:    cfg_reg.z_limit     <= cfg_wdata[14:0];
                CFG_YAW_LIMIT:  cfg_reg.yaw_limit   <= cfg_wdata[14:0];
                CFG_BOUNDS_EN:  cfg_reg.bounds_en   <= cfg_wdata[0];
                CFG_MIN_BOUNDS: cfg_reg.min_bounds  <= cfg_wdata;
                CFG_MAX_BOUNDS: cfg_reg.max_bounds  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer: clear in idle, or smoothing, squares, root, optional xy scaling, commit
    vcss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // held command, shared multiplier, root and divide units, output register
    vcss_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .st             (st),
        .s_op           (s_op),
        .s_measured_vx  (s_measured_vx),
        .s_measured_vy  (s_measured_vy),
        .s_measured_vz  (s_measured_vz),
        .s_cmd_vx       (s_cmd_vx),
        .s_cmd_vy       (s_cmd_vy),
        .s_cmd_vz       (s_cmd_vz),
        .s_cmd_yaw_rate (s_cmd_yaw_rate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_vx       (m_out_vx),
        .m_out_vy       (m_out_vy),
        .m_out_vz       (m_out_vz),
        .m_out_yaw_rate (m_out_yaw_rate)
    );

endmodule
`default_nettype wire
